// ===== hdl/serial_command_line_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial command line decoder
// Both macros assume a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_DECODER_TOP_DEFINES_SVH
`define SERIAL_COMMAND_LINE_DECODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/scld_pkg.sv =====
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types, command table and result codes of the command line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scld_pkg;

    localparam int CMD_COUNT   = 5;
    localparam int CMD_MAX_LEN = 9;
    localparam int CODE_W      = 3;
    localparam int POS_W       = 8;

    // Result codes
    localparam logic [CODE_W-1:0] CODE_HELP      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_TEST_UART = 3'd1;
    localparam logic [CODE_W-1:0] CODE_TEST_GPIO = 3'd2;
    localparam logic [CODE_W-1:0] CODE_TEST_ADC  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TEST_ALL  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN   = 3'd5;
    localparam logic [CODE_W-1:0] CODE_TOO_LONG  = 3'd6;

    // Special characters
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Command lengths, indexed by result code
    localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{4'd4, 4'd9, 4'd9, 4'd8, 4'd8};

    // Command text, padded with zero bytes
    localparam logic [7:0] CMD_TEXT [CMD_COUNT][CMD_MAX_LEN] = '{
        '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "E", "S", "T", " ", "U", "A", "R", "T"},
        '{"T", "E", "S", "T", " ", "G", "P", "I", "O"},
        '{"T", "E", "S", "T", " ", "A", "D", "C", 8'h00},
        '{"T", "E", "S", "T", " ", "A", "L", "L", 8'h00}
    };

    // One word waiting between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       is_term;
        logic       is_zero;
    } item_t;

    // Line status reported by the back end
    typedef struct packed {
        logic                 emit;
        logic                 line_empty;
        logic                 zero_seen;
        logic [CMD_COUNT-1:0] match_alive;
    } line_status_t;

    // True when byte b matches command k at position pos
    function automatic logic cmd_char_match(input logic [2:0] k,
                                            input logic [POS_W-1:0] pos,
                                            input logic [7:0] b);
        logic in_range;
        in_range = (pos < POS_W'(CMD_LEN[k]));
        return in_range && (CMD_TEXT[k][pos[3:0]] == b);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scld_front.sv =====
// ----------------------------------------------------------------------------
// scld_front
// Classifies each received byte as terminator, zero byte or ordinary text.
// ----------------------------------------------------------------------------
`default_nettype none

module scld_front (
    input  wire logic [7:0]    rx_data,
    output scld_pkg::item_t    item
);
    import scld_pkg::*;

    always_comb
    begin
        item.data    = rx_data;
        item.is_term = (rx_data == CHAR_CR) || (rx_data == CHAR_LF);
        item.is_zero = (rx_data == CHAR_NUL);
    end

endmodule

`default_nettype wire

// ===== hdl/scld_queue.sv =====
// ----------------------------------------------------------------------------
// scld_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scld_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  scld_pkg::item_t    push_item,
    output logic               full,
    input  wire logic          pop,
    output logic               pop_valid,
    output scld_pkg::item_t    pop_item
);
    import scld_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/scld_back.sv =====
// ----------------------------------------------------------------------------
// scld_back
// Holds the line state, matches text against the commands, drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module scld_back #(
    parameter int LINE_CAPACITY = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  scld_pkg::item_t                    item,
    output logic                               item_pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [scld_pkg::CODE_W-1:0]        out_code,
    output scld_pkg::line_status_t             status
);
    import scld_pkg::*;

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] LAST_POS = CW'(LINE_CAPACITY - 1);
    localparam logic [CMD_COUNT-1:0] ALL_ALIVE = '1;

    logic [CW-1:0]        char_count_reg;
    logic [CW-1:0]        char_count_next;
    logic [CW-1:0]        text_length_reg;
    logic [CW-1:0]        text_length_next;
    logic                 zero_seen_reg;
    logic                 zero_seen_next;
    logic [CMD_COUNT-1:0] match_alive_reg;
    logic [CMD_COUNT-1:0] match_alive_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;

    logic                 fire;
    logic                 emit;
    logic [CMD_COUNT-1:0] char_ok;
    logic [CODE_W-1:0]    decided;

    // Take a word only when the result register is free or being emptied
    assign fire     = item_valid && (!out_valid_reg || out_ready);
    assign item_pop = fire;

    always_comb
    begin
        for (int k = 0; k < CMD_COUNT; k++)
        begin
            char_ok[k] = cmd_char_match(3'(k), POS_W'(char_count_reg), item.data);
        end

        // Lowest matching code wins
        decided = CODE_UNKNOWN;
        for (int k = CMD_COUNT - 1; k >= 0; k--)
        begin
            if (match_alive_reg[k] && (POS_W'(text_length_reg) == POS_W'(CMD_LEN[3'(k)])))
            begin
                decided = 3'(k);
            end
        end
    end

    always_comb
    begin
        char_count_next  = char_count_reg;
        text_length_next = text_length_reg;
        zero_seen_next   = zero_seen_reg;
        match_alive_next = match_alive_reg;
        code_next        = code_reg;
        emit             = 1'b0;

        if (fire)
        begin
            priority if (item.is_term)
            begin
                if (char_count_reg != '0)
                begin
                    emit             = 1'b1;
                    code_next        = decided;
                    char_count_next  = '0;
                    text_length_next = '0;
                    zero_seen_next   = 1'b0;
                    match_alive_next = ALL_ALIVE;
                end
            end
            else if (char_count_reg != LAST_POS)
            begin
                char_count_next = char_count_reg + 1'b1;
                if (!zero_seen_reg)
                begin
                    if (item.is_zero)
                    begin
                        zero_seen_next = 1'b1;
                    end
                    else
                    begin
                        match_alive_next = match_alive_reg & char_ok;
                        text_length_next = char_count_reg + 1'b1;
                    end
                end
            end
            else
            begin
                // Line full: drop the byte and clear the line
                emit             = 1'b1;
                code_next        = CODE_TOO_LONG;
                char_count_next  = '0;
                text_length_next = '0;
                zero_seen_next   = 1'b0;
                match_alive_next = ALL_ALIVE;
            end
        end

        out_valid_next = emit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg  <= '0;
            text_length_reg <= '0;
            zero_seen_reg   <= 1'b0;
            match_alive_reg <= ALL_ALIVE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            char_count_reg  <= char_count_next;
            text_length_reg <= text_length_next;
            zero_seen_reg   <= zero_seen_next;
            match_alive_reg <= match_alive_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign out_valid = out_valid_reg;
    assign out_code  = code_reg;

    always_comb
    begin
        status.emit        = emit;
        status.line_empty  = (char_count_reg == '0);
        status.zero_seen   = zero_seen_reg;
        status.match_alive = match_alive_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/serial_command_line_decoder_top.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_decoder_top: command line decoder for a serial link
// Path: an accepted byte is written into the queue, then the line state update registers the result.
// Throughput: one byte per cycle while a stalled result sink does not hold the line state update.
// Reset: asynchronous, active low; clears the line and empties queue and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_command_line_decoder_top_defines.svh"

module serial_command_line_decoder_top #(
    parameter int LINE_CAPACITY = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Received byte stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    // Result stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [2:0] command_code, [7:3] zero
);
    import scld_pkg::*;

    item_t             front_item;
    item_t             queue_item;
    logic              queue_full;
    logic              queue_valid;
    logic              queue_pop;
    logic              in_fire;
    logic [CODE_W-1:0] result_code;
    line_status_t      line_status;

    // Front end: classify the incoming word. The queue takes it whenever
    // there is room, so ready never waits on the back end directly.
    assign s_axis_tready = !queue_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    scld_front u_front (
        .rx_data (s_axis_tdata),
        .item    (front_item)
    );

    // Two entries keep the stream moving at full rate: in steady state the
    // back end drains one word for every word the front end pushes.
    scld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_valid (queue_valid),
        .pop_item  (queue_item)
    );

    // Back end: advance the line state and hold any result in its output
    // register until the sink takes it.
    scld_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_code   (result_code),
        .status     (line_status)
    );

    // Pad the result code up to a whole byte
    assign m_axis_tdata = {{(8 - CODE_W){1'b0}}, result_code};

    // A zero byte is only ever recorded on a line that holds characters
    `SCLD_ASSERT_NOW(a_zero_needs_chars, line_status.zero_seen, !line_status.line_empty,
        "zero byte flagged on an empty line")

    // An empty line keeps every command candidate alive
    `SCLD_ASSERT_NOW(a_empty_all_alive, line_status.line_empty,
        line_status.match_alive == {CMD_COUNT{1'b1}},
        "empty line with a command flag cleared")

    // Every result clears the line and is presented on the next cycle
    `SCLD_ASSERT_NEXT(a_emit_clears, line_status.emit,
        line_status.line_empty && m_axis_tvalid,
        "result issued without clearing the line")

    // Only defined codes leave the block
    `SCLD_ASSERT_NOW(a_code_defined, m_axis_tvalid, m_axis_tdata[2:0] <= CODE_TOO_LONG,
        "undefined command code on output")

endmodule

`default_nettype wire

// ===== tb/sv/serial_command_line_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// Serial command line decoder testbench
// Streams received bytes into the decoder and checks every command code that
// comes back against a line model kept inside the bench. A short directed
// pass covers each command, empty lines, embedded zero bytes and full lines.
// Random lines follow, most of them close to real commands, under bursty
// input, a stalling result sink, one long sink hold-off and drained pauses.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scld_pkg::*;

    localparam int LINE_CAP       = 32;
    localparam int SPAN_W         = $clog2(LINE_CAP);
    localparam int RANDOM_BYTES   = 1080;
    localparam int PAUSE_EVERY    = 350;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int STUCK_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PRINT_CAP      = 40;

    // Clock, reset and the two stream groups
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [2:0] command_code, [7:3] zero

    // Known commands, in code order
    string cmd_name [CMD_COUNT] = '{"HELP", "TEST UART", "TEST GPIO", "TEST ADC", "TEST ALL"};
    logic [CODE_W-1:0] cmd_code_tab [CMD_COUNT] =
        '{CODE_HELP, CODE_TEST_UART, CODE_TEST_GPIO, CODE_TEST_ADC, CODE_TEST_ALL};

    // Line model state
    logic [SPAN_W-1:0]    line_fill;
    logic [SPAN_W-1:0]    text_span;
    logic                 nul_hit;
    logic [CMD_COUNT-1:0] still_match;

    // Bytes waiting for the driver, codes waiting for the monitor
    logic [7:0]        rx_pending_q [$];
    logic [CODE_W-1:0] command_code_q [$];

    int bytes_pushed = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int pauses_done  = 0;
    int code_seen [8];

    // Sender burst shaping
    int burst_left;
    int gap_left;

    // Sink stall shaping and the one long hold-off
    logic holdoff_req  = 1'b0;
    logic holdoff_done = 1'b0;
    int   holdoff_left;
    int   sink_mode;
    int   sink_left;
    int   sink_phase;

    int stuck_cycles = 0;

    serial_command_line_decoder_top #(
        .LINE_CAPACITY (LINE_CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------

    function automatic void clear_line_state();
        line_fill   = '0;
        text_span   = '0;
        nul_hit     = 1'b0;
        still_match = '1;
    endfunction

    // Advance the line model by one accepted byte and queue any code it ends in.
    function automatic void predict_command_code(input logic [7:0] b);
        int                k;
        int                pos;
        logic [CODE_W-1:0] code;
        if (b == CHAR_CR || b == CHAR_LF)
        begin
            // A terminator on an empty line leaves everything as it is
            if (line_fill != 0)
            begin
                // Lowest matching code wins, so scan downwards and overwrite
                code = CODE_UNKNOWN;
                for (k = CMD_COUNT - 1; k >= 0; k--)
                    if (still_match[k] && int'(text_span) == cmd_name[k].len())
                        code = cmd_code_tab[k];
                command_code_q.push_back(code);
                clear_line_state();
            end
        end
        else if (int'(line_fill) < LINE_CAP - 1)
        begin
            pos       = line_fill;
            line_fill = line_fill + 1'b1;
            // After the first zero byte the text is frozen, only the count moves
            if (!nul_hit)
            begin
                if (b == CHAR_NUL)
                    nul_hit = 1'b1;
                else
                begin
                    for (k = 0; k < CMD_COUNT; k++)
                        if (pos >= cmd_name[k].len() || cmd_name[k][pos] != b)
                            still_match[k] = 1'b0;
                    text_span = SPAN_W'(pos + 1);
                end
            end
        end
        else
        begin
            // Line full: drop the byte, flag it and start afresh
            clear_line_state();
            command_code_q.push_back(CODE_TOO_LONG);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s (got %02h, want %02h)", $realtime, what, got, want);
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_pending_q.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Any byte but a terminator
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    task automatic push_plain(input int n);
        repeat (n)
            push_byte(plain_byte());
    endtask

    // CR, LF or a pair of them; the second of a pair meets an empty line
    task automatic push_end();
        case ($urandom_range(0, 3))
            0: push_byte(CHAR_CR);
            1: push_byte(CHAR_LF);
            2: begin push_byte(CHAR_CR); push_byte(CHAR_LF); end
            default: begin push_byte(CHAR_LF); push_byte(CHAR_CR); end
        endcase
    endtask

    // A known command, left whole half of the time, otherwise bent a little
    task automatic push_command_line();
        int    k;
        int    i;
        int    cut;
        int    spot;
        int    variant;
        string s;
        k       = $urandom_range(0, CMD_COUNT - 1);
        s       = cmd_name[k];
        variant = $urandom_range(0, 9);
        cut     = s.len();
        spot    = -1;
        if (variant == 5)
            spot = $urandom_range(0, s.len() - 1);
        if (variant == 6)
            cut = $urandom_range(1, s.len() - 1);
        if (variant == 9)
            cut = $urandom_range(0, s.len());
        for (i = 0; i < cut; i++)
            push_byte((i == spot) ? plain_byte() : 8'(s[i]));
        if (variant == 7)
            push_plain($urandom_range(1, 4));
        // A zero byte cuts the compare short, whatever follows it
        if (variant >= 8)
        begin
            push_byte(CHAR_NUL);
            push_plain($urandom_range(0, 6));
        end
        push_end();
    endtask

    // Hold the sender back until every queued byte is taken and every code is in
    task automatic drain_all();
        while (bytes_sent != bytes_pushed)
            @(posedge clk);
        while (command_code_q.size() != 0)
            @(posedge clk);
        pauses_done++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued bytes in bursts, predicts on every accepted word
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            burst_left    <= 0;
            gap_left      <= 0;
            clear_line_state();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_command_code(s_axis_tdata);
                bytes_sent++;
            end
            // Load a new word only once the current one has gone
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (rx_pending_q.size() != 0)
                begin
                    s_axis_tdata  <= rx_pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // End of burst: a quarter of bursts run straight on
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: stall pattern picks one of four modes and holds it for a random count of cycles
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            holdoff_done  <= 1'b0;
            holdoff_left  <= 0;
            sink_mode     <= 0;
            sink_left     <= 0;
            sink_phase    <= 0;
        end
        else if (holdoff_req && !holdoff_done)
        begin
            // Start the long hold-off so the decoder backs up into its input
            holdoff_done  <= 1'b1;
            holdoff_left  <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left  <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (sink_left == 0)
            begin
                sink_mode <= $urandom_range(0, 3);
                sink_left <= $urandom_range(8, 64);
            end
            else
                sink_left <= sink_left - 1;
            sink_phase <= sink_phase + 1;
            case (sink_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (sink_phase % 4 != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted word must match the oldest queued code
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            code_seen[m_axis_tdata[2:0]]++;
            if (command_code_q.size() == 0)
                report_mismatch("result with no code expected", m_axis_tdata, 8'h00);
            else
            begin
                // Padding above the code must read as zero too
                want = {5'b00000, command_code_q.pop_front()};
                if (m_axis_tdata !== want)
                    report_mismatch("command code", m_axis_tdata, want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after too long without any word moving
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed lines, then random lines
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int pick;
        int random_base;
        int next_pause;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Every command, with each terminator form
        push_text("HELP");      push_byte(CHAR_CR);
        push_text("TEST UART"); push_byte(CHAR_LF);
        push_text("TEST GPIO"); push_byte(CHAR_CR); push_byte(CHAR_LF);
        push_text("TEST ADC");  push_byte(CHAR_CR);
        push_text("TEST ALL");  push_byte(CHAR_LF);
        // Terminator on an empty line
        push_byte(CHAR_CR);
        // Text after a zero byte is ignored, so this is still HELP
        push_text("HELP"); push_byte(CHAR_NUL); push_text("XY"); push_byte(CHAR_CR);
        // Line starting with a zero byte
        push_byte(CHAR_NUL); push_byte(CHAR_CR);
        // Prefix and extension of a command
        push_text("HEL");   push_byte(CHAR_CR);
        push_text("HELPS"); push_byte(CHAR_LF);
        // Top byte value
        push_byte(8'hFF); push_byte(CHAR_CR);
        // Longest line that still fits
        push_plain(LINE_CAP - 1); push_byte(CHAR_CR);
        // One over: too long, then the terminator meets an empty line
        push_plain(LINE_CAP); push_byte(CHAR_CR);
        // Two over: the extra byte opens a fresh line
        push_plain(LINE_CAP + 1); push_byte(CHAR_LF);
        drain_all();

        random_base = bytes_pushed;
        next_pause  = bytes_pushed + PAUSE_EVERY;
        while (bytes_pushed < random_base + RANDOM_BYTES)
        begin
            // Keep the pending queue short so pauses and hold-offs land mid-run
            while (rx_pending_q.size() > 24)
                @(posedge clk);
            if (!holdoff_req && bytes_pushed - random_base > 500)
            begin
                @(posedge clk);
                holdoff_req <= 1'b1;
                // Keep offering lines while the sink sits on its hands
                repeat (40)
                    push_command_line();
            end
            if (bytes_pushed >= next_pause)
            begin
                drain_all();
                next_pause = bytes_pushed + PAUSE_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                push_command_line();
            else if (pick < 75)
            begin
                // Raw noise, terminators included
                repeat ($urandom_range(1, 12))
                    push_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 87)
            begin
                // Around the line limit
                push_plain($urandom_range(LINE_CAP - 3, LINE_CAP + 8));
                push_end();
            end
            else if (pick < 94)
                push_end();
            else
            begin
                push_byte(CHAR_NUL);
                push_plain($urandom_range(0, 5));
                push_end();
            end
        end

        // Let everything through, then allow for the pipeline to settle
        drain_all();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (command_code_q.size() != 0)
            report_mismatch("codes never delivered", 8'(command_code_q.size()), 8'h00);

        $display("Covered %0d bytes, %0d codes returned, %0d drained pauses, %0d-cycle sink hold-off.",
                 bytes_sent, results_seen, pauses_done, HOLDOFF_CYCLES);
        $display("Codes: help %0d, uart %0d, gpio %0d, adc %0d, all %0d, unknown %0d, too long %0d",
                 code_seen[CODE_HELP], code_seen[CODE_TEST_UART], code_seen[CODE_TEST_GPIO],
                 code_seen[CODE_TEST_ADC], code_seen[CODE_TEST_ALL], code_seen[CODE_UNKNOWN],
                 code_seen[CODE_TOO_LONG]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
